// ----- hdl/bgfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bgfb_pkg;

    localparam int TIME_BITS_DEFAULT = 48;
    localparam int OPCODE_BITS       = 2;
    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 16;
    localparam int POSITION_BITS     = 8;
    localparam int METHOD_BITS       = 5;
    localparam int APPLIED_BITS      = 9;

    localparam logic [CFG_ADDR_BITS-1:0] REG_BURST_LIMIT    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_MS      = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_MS        = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RETRY_DELAY_MS = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_FAILURES   = 3'd4;

    localparam logic [7:0]  BURST_LIMIT_RST    = 8'd3;
    localparam logic [15:0] WINDOW_MS_RST      = 16'd3000;
    localparam logic [15:0] HOLD_MS_RST        = 16'd5000;
    localparam logic [15:0] RETRY_DELAY_MS_RST = 16'd1500;
    localparam logic [7:0]  MAX_FAILURES_RST   = 8'd3;

    localparam logic [APPLIED_BITS-1:0] POSITION_NONE = 9'h1FF;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CHECK     = 2'd0,
        OP_COMPLETE  = 2'd1,
        OP_RESET_REC = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [7:0]  burst_limit;
        logic [15:0] window_ms;
        logic [15:0] hold_ms;
        logic [15:0] retry_delay_ms;
        logic [7:0]  max_failures;
    } t_cfg;

    typedef struct packed {
        logic last_ok;
        logic suspended_now;
        logic report_failure;
        logic recovered;
        logic guard_tripped;
        logic allowed;
    } t_flags;

endpackage

`default_nettype wire

// ----- hdl/bgfb_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bgfb_cfg (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bgfb_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  wire logic [bgfb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output bgfb_pkg::t_cfg                            o_cfg
);

    bgfb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_limit    <= bgfb_pkg::BURST_LIMIT_RST;
            r_cfg.window_ms      <= bgfb_pkg::WINDOW_MS_RST;
            r_cfg.hold_ms        <= bgfb_pkg::HOLD_MS_RST;
            r_cfg.retry_delay_ms <= bgfb_pkg::RETRY_DELAY_MS_RST;
            r_cfg.max_failures   <= bgfb_pkg::MAX_FAILURES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bgfb_pkg::REG_BURST_LIMIT:    r_cfg.burst_limit    <= i_cfg_data[7:0];
                bgfb_pkg::REG_WINDOW_MS:      r_cfg.window_ms      <= i_cfg_data;
                bgfb_pkg::REG_HOLD_MS:        r_cfg.hold_ms        <= i_cfg_data;
                bgfb_pkg::REG_RETRY_DELAY_MS: r_cfg.retry_delay_ms <= i_cfg_data;
                bgfb_pkg::REG_MAX_FAILURES:   r_cfg.max_failures   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/bgfb_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bgfb_engine #(
    parameter int TIME_BITS = bgfb_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bgfb_pkg::t_cfg                       i_cfg,
    input  wire logic                                 i_fire,
    input  wire bgfb_pkg::t_opcode                    i_op,
    input  wire logic [TIME_BITS-1:0]                 i_now,
    input  wire logic                                 i_bounce_guard,
    input  wire logic [bgfb_pkg::POSITION_BITS-1:0]   i_position,
    input  wire logic                                 i_was_accepted,
    input  wire logic                                 i_is_automatic,
    output bgfb_pkg::t_flags                          o_flags,
    output logic [TIME_BITS-1:0]                      o_retry_due,
    output logic [bgfb_pkg::APPLIED_BITS-1:0]         o_applied_position
);

    logic                                r_suspended, n_suspended;
    logic [TIME_BITS-1:0]                r_guard_until, n_guard_until;
    logic [TIME_BITS-1:0]                r_window_start, n_window_start;
    logic [7:0]                          r_burst_count, n_burst_count;
    logic [7:0]                          r_failure_count, n_failure_count;
    logic                                r_failure_reported, n_failure_reported;
    logic [TIME_BITS-1:0]                r_retry_time, n_retry_time;
    logic                                r_last_success, n_last_success;
    logic [bgfb_pkg::APPLIED_BITS-1:0]   r_last_position, n_last_position;

    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_new_window;
    logic [7:0]           w_burst_base;
    logic [8:0]           w_burst_next;
    logic [8:0]           w_fail_next;
    logic [8:0]           w_fail_limit;
    logic [TIME_BITS-1:0] w_hold_end;
    logic [TIME_BITS-1:0] w_retry_end;
    logic                 w_allow;
    logic                 w_trip;
    logic                 w_recov;
    logic                 w_report;

    function automatic logic [TIME_BITS-1:0] f_time_add(
        input logic [TIME_BITS-1:0] t,
        input logic [15:0]          d
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + {{(TIME_BITS-15){1'b0}}, d};
        f_time_add = s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    always_comb begin
        w_elapsed    = i_now - r_window_start;
        w_new_window = (r_window_start == '0) ||
                       ((i_now > r_window_start) &&
                        (w_elapsed > {{(TIME_BITS-16){1'b0}}, i_cfg.window_ms}));
        w_burst_base = w_new_window ? 8'd0 : r_burst_count;
        w_burst_next = {1'b0, w_burst_base} + 9'd1;
        w_fail_next  = {1'b0, r_failure_count} + 9'd1;
        w_fail_limit = (i_cfg.max_failures == 8'd0) ? 9'd1 : {1'b0, i_cfg.max_failures};
        w_hold_end   = f_time_add(i_now, i_cfg.hold_ms);
        w_retry_end  = f_time_add(i_now, i_cfg.retry_delay_ms);

        n_suspended        = r_suspended;
        n_guard_until      = r_guard_until;
        n_window_start     = r_window_start;
        n_burst_count      = r_burst_count;
        n_failure_count    = r_failure_count;
        n_failure_reported = r_failure_reported;
        n_retry_time       = r_retry_time;
        n_last_success     = r_last_success;
        n_last_position    = r_last_position;
        w_allow            = 1'b0;
        w_trip             = 1'b0;
        w_recov            = 1'b0;
        w_report           = 1'b0;

        case (i_op)
            bgfb_pkg::OP_CHECK: begin
                if (!(r_suspended && (i_now < r_guard_until))) begin
                    n_suspended = 1'b0;
                    if (!i_bounce_guard) begin
                        w_allow = 1'b1;
                    end else if (!(i_now < r_guard_until)) begin
                        if (w_new_window) begin
                            n_window_start = i_now;
                        end
                        if (w_burst_next > {1'b0, i_cfg.burst_limit}) begin
                            n_guard_until = w_hold_end;
                            n_burst_count = 8'd0;
                            w_trip        = 1'b1;
                        end else begin
                            n_burst_count = w_burst_next[7:0];
                            w_allow       = 1'b1;
                        end
                    end
                end
            end
            bgfb_pkg::OP_COMPLETE: begin
                if (i_was_accepted) begin
                    n_last_position    = {1'b0, i_position};
                    n_last_success     = 1'b1;
                    w_recov            = (r_failure_count != 8'd0) || r_failure_reported;
                    n_failure_count    = 8'd0;
                    n_failure_reported = 1'b0;
                    n_retry_time       = '0;
                    n_suspended        = 1'b0;
                end else begin
                    n_last_success = 1'b0;
                    n_retry_time   = w_retry_end;
                    if (i_is_automatic) begin
                        if (w_fail_next < w_fail_limit) begin
                            n_failure_count = w_fail_next[7:0];
                        end else begin
                            n_failure_count    = 8'd0;
                            n_guard_until      = w_hold_end;
                            n_suspended        = 1'b1;
                            n_retry_time       = w_hold_end;
                            w_report           = !r_failure_reported;
                            n_failure_reported = 1'b1;
                        end
                    end
                end
            end
            bgfb_pkg::OP_RESET_REC: begin
                n_suspended        = 1'b0;
                n_failure_count    = 8'd0;
                n_failure_reported = 1'b0;
                n_retry_time       = '0;
                n_burst_count      = 8'd0;
                n_guard_until      = '0;
                n_window_start     = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suspended        <= 1'b0;
            r_guard_until      <= '0;
            r_window_start     <= '0;
            r_burst_count      <= 8'd0;
            r_failure_count    <= 8'd0;
            r_failure_reported <= 1'b0;
            r_retry_time       <= '0;
            r_last_success     <= 1'b0;
            r_last_position    <= bgfb_pkg::POSITION_NONE;
        end else if (i_fire) begin
            r_suspended        <= n_suspended;
            r_guard_until      <= n_guard_until;
            r_window_start     <= n_window_start;
            r_burst_count      <= n_burst_count;
            r_failure_count    <= n_failure_count;
            r_failure_reported <= n_failure_reported;
            r_retry_time       <= n_retry_time;
            r_last_success     <= n_last_success;
            r_last_position    <= n_last_position;
        end
    end

    always_comb begin
        o_flags.allowed        = w_allow;
        o_flags.guard_tripped  = w_trip;
        o_flags.recovered      = w_recov;
        o_flags.report_failure = w_report;
        o_flags.suspended_now  = n_suspended;
        o_flags.last_ok        = n_last_success;
        o_retry_due            = n_retry_time;
        o_applied_position     = n_last_position;
    end

endmodule

`default_nettype wire

// ----- hdl/burst_guard_failure_breaker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Admission guard and failure breaker for automatic position requests. Every request
// (check, completion or recovery reset, selected by tuser) passes an input register and
// lands in a result register when it advances; one request is accepted every cycle while
// the master side does not stall, since the whole state update is combinational between
// those two registers. The input register can take a new request while a finished result
// still waits on the master side. Configuration takes effect on the next request.
module burst_guard_failure_breaker_top #(
    parameter int TIME_BITS = bgfb_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bgfb_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  wire logic [bgfb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // now_ms, bounce_guard, position, method_code, was_accepted, is_automatic
    input  wire logic [((TIME_BITS+16+7)/8)*8-1:0]    s_axis_tdata,
    // opcode
    input  wire logic [bgfb_pkg::OPCODE_BITS-1:0]     s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // allowed, guard_tripped, recovered, report_failure, suspended_now, retry_due,
    // applied_position, last_ok
    output logic [((TIME_BITS+15+7)/8)*8-1:0]         m_axis_tdata
);

    localparam int IN_DATA_W  = ((TIME_BITS + 16 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((TIME_BITS + 15 + 7) / 8) * 8;

    bgfb_pkg::t_cfg   w_cfg;
    bgfb_pkg::t_flags w_flags;
    logic [TIME_BITS-1:0]              w_retry_due;
    logic [bgfb_pkg::APPLIED_BITS-1:0] w_applied;

    logic                             r_in_valid;
    logic [IN_DATA_W-1:0]             r_in_data;
    logic [bgfb_pkg::OPCODE_BITS-1:0] r_in_user;
    logic                             r_out_valid;
    logic [OUT_DATA_W-1:0]            r_out_data, n_out_data;
    logic                             w_adv;

    bgfb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    bgfb_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_fire             (w_adv),
        .i_op               (bgfb_pkg::t_opcode'(r_in_user)),
        .i_now              (r_in_data[TIME_BITS-1:0]),
        .i_bounce_guard     (r_in_data[TIME_BITS]),
        .i_position         (r_in_data[TIME_BITS+8:TIME_BITS+1]),
        .i_was_accepted     (r_in_data[TIME_BITS+14]),
        .i_is_automatic     (r_in_data[TIME_BITS+15]),
        .o_flags            (w_flags),
        .o_retry_due        (w_retry_due),
        .o_applied_position (w_applied)
    );

    always_comb begin
        n_out_data                               = '0;
        n_out_data[0]                            = w_flags.allowed;
        n_out_data[1]                            = w_flags.guard_tripped;
        n_out_data[2]                            = w_flags.recovered;
        n_out_data[3]                            = w_flags.report_failure;
        n_out_data[4]                            = w_flags.suspended_now;
        n_out_data[TIME_BITS+4:5]                = w_retry_due;
        n_out_data[TIME_BITS+13:TIME_BITS+5]     = w_applied;
        n_out_data[TIME_BITS+14]                 = w_flags.last_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_data) && $stable(r_in_user)))
        else $error("pending request lost or overwritten");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("check both allowed and tripped");

    a_report_susp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[3]) |-> (r_out_data[4] && !r_out_data[TIME_BITS+14]))
        else $error("failure report without suspension");

    a_recov_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[2]) |-> (r_out_data[TIME_BITS+14] && !r_out_data[4]))
        else $error("recovery without successful dispatch");
`endif

endmodule

`default_nettype wire
